/* hw/rtl/rcwt_pkg.sv */
// ----------------------------------------------------------------------------
// rcwt_pkg
// Shared constants, codes and controller/datapath signal groups for the
// wall column texturer.
// ----------------------------------------------------------------------------
package rcwt_pkg;

	localparam int SCREEN_HEIGHT_DEF = 480;

	localparam int OPC_W      = 1;
	localparam int DIST_W     = 24;
	localparam int COL_W      = 10;
	localparam int TCOL_W     = 10;
	localparam int ROW_OUT_W  = 9;
	localparam int TEXEL_W    = 20;
	localparam int HLOG_W     = 4;
	localparam int TEXW_W     = 11;
	localparam int POS_W      = 32;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [OPC_W-1:0] OP_START = 1'b0;
	localparam logic [OPC_W-1:0] OP_PIXEL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TEX_H_LOG2 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b1;

	typedef enum logic [1:0] {
		DIV_LH   = 2'd0,
		DIV_STEP = 2'd1,
		DIV_POS  = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     cap_item;
		logic     div_go;
		div_sel_t div_sel;
		logic     cap_lh;
		logic     cap_step;
		logic     cap_pos;
		logic     commit;
		logic     pixel;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic lh_zero;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/rcwt_div.sv */
// ----------------------------------------------------------------------------
// rcwt_div
// Restoring divider, one quotient bit per cycle; keeps the low 32 bits
// of the quotient.
// ----------------------------------------------------------------------------
module rcwt_div #(
	parameter int NUM_W = 55,
	parameter int DEN_W = 26
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [NUM_W-1:0]         num,
	input  logic [DEN_W-1:0]         den,
	output logic                     busy,
	output logic                     done,
	output logic [rcwt_pkg::POS_W-1:0] quo
);
	import rcwt_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [POS_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] diff;
	logic           ge;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[POS_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* hw/rtl/rcwt_ctrl.sv */
// ----------------------------------------------------------------------------
// rcwt_ctrl
// Sequencer: accepts words, runs up to three column setup divisions and
// hands results to the output register.
// ----------------------------------------------------------------------------
module rcwt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic [rcwt_pkg::OPC_W-1:0]     opcode,
	output logic                           item_ready,
	input  rcwt_pkg::sts_t                 sts,
	output rcwt_pkg::cmd_t                 cmd
);
	import rcwt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LH     = 6'b000010,
		S_SETUP  = 6'b000100,
		S_STEP   = 6'b001000,
		S_POS    = 6'b010000,
		S_COMMIT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt  = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		cmd.div_sel = DIV_LH;
		case (state_q)
			S_IDLE: begin
				item_ready = (opcode == OP_START) || sts.out_free;
				if (item_valid && item_ready) begin
					if (opcode == OP_START) begin
						cmd.cap_item = 1'b1;
						cmd.div_go   = 1'b1;
						cmd.div_sel  = DIV_LH;
						state_nxt    = S_LH;
					end else begin
						cmd.pixel = 1'b1;
					end
				end
			end
			S_LH: begin
				if (sts.div_done) begin
					cmd.cap_lh = 1'b1;
					state_nxt  = S_SETUP;
				end
			end
			S_SETUP: begin
				if (sts.lh_zero) begin
					state_nxt = S_COMMIT;
				end else begin
					cmd.div_go  = 1'b1;
					cmd.div_sel = DIV_STEP;
					state_nxt   = S_STEP;
				end
			end
			S_STEP: begin
				if (sts.div_done) begin
					cmd.cap_step = 1'b1;
					cmd.div_go   = 1'b1;
					cmd.div_sel  = DIV_POS;
					state_nxt    = S_POS;
				end
			end
			S_POS: begin
				if (sts.div_done) begin
					cmd.cap_pos = 1'b1;
					state_nxt   = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("start result loaded while output register full");

	a_pixel_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pixel |-> sts.out_free)
		else $error("pixel word taken while output register full");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |-> !sts.div_busy)
		else $error("divider launched while busy");

endmodule

/* hw/rtl/rcwt_dp.sv */
// ----------------------------------------------------------------------------
// rcwt_dp
// Datapath: config registers, column state, span and texture setup,
// texel addressing and the result register.
// ----------------------------------------------------------------------------
module rcwt_dp #(
	parameter int SCREEN_HEIGHT = rcwt_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rcwt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rcwt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [rcwt_pkg::DIST_W-1:0]         wall_distance_q16,
	input  logic [rcwt_pkg::COL_W-1:0]          column,
	input  logic [rcwt_pkg::TCOL_W-1:0]         texture_column,
	input  rcwt_pkg::cmd_t                      cmd,
	output rcwt_pkg::sts_t                      sts,
	input  logic                                result_ready,
	output logic                                result_valid,
	output logic [rcwt_pkg::ROW_OUT_W-1:0]      span_start,
	output logic [rcwt_pkg::ROW_OUT_W-1:0]      span_end,
	output logic                                pixel_valid,
	output logic [rcwt_pkg::COL_W-1:0]          screen_column,
	output logic [rcwt_pkg::ROW_OUT_W-1:0]      screen_row,
	output logic [rcwt_pkg::TEXEL_W-1:0]        texel_index,
	output logic                                last_pixel
);
	import rcwt_pkg::*;

	localparam int HGT_W  = $clog2(SCREEN_HEIGHT + 1);
	localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
	localparam int DEN_W  = (HGT_W + 17 > DIST_W) ? HGT_W + 17 : DIST_W;
	localparam int NUM_W  = HGT_W + 46;
	localparam int HALF_H = SCREEN_HEIGHT / 2;
	localparam int PROD_W = 2 * FRAC_W - FRAC_W + TEXW_W;

	logic [HLOG_W-1:0] tex_h_log2_q;
	logic [TEXW_W-1:0] tex_width_q;

	logic [ROW_W-1:0]  cur_row_q;
	logic [ROW_W-1:0]  end_row_q;
	logic [POS_W-1:0]  tex_pos_q;
	logic [POS_W-1:0]  tex_step_q;
	logic [COL_W-1:0]  saved_col_q;
	logic [TCOL_W-1:0] saved_tcol_q;

	logic              dist_zero_q;
	logic [DEN_W-1:0]  lh_q;
	logic [POS_W-1:0]  step_new_q;
	logic [POS_W-1:0]  pos_new_q;

	logic              res_valid_q;
	logic [ROW_OUT_W-1:0] span_start_q;
	logic [ROW_OUT_W-1:0] span_end_q;
	logic              pix_valid_q;
	logic [COL_W-1:0]  scr_col_q;
	logic [ROW_OUT_W-1:0] scr_row_q;
	logic [TEXEL_W-1:0] texel_q;
	logic              last_q;

	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_busy;
	logic              div_done;
	logic [POS_W-1:0]  div_quo;

	logic [5:0]        shamt;
	logic [DEN_W-1:0]  half;
	logic [DEN_W-1:0]  offset;
	logic [DEN_W:0]    end_sum;
	logic [ROW_W-1:0]  start_row;
	logic [ROW_W-1:0]  end_row;
	logic              lh_zero;
	logic              out_free;

	logic              pix_active;
	logic [FRAC_W-1:0] hmask;
	logic [FRAC_W-1:0] trow;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] idx_sum;
	logic              pix_last;

	// column setup arithmetic
	assign lh_zero = (lh_q == '0);
	assign shamt   = 6'(tex_h_log2_q) + 6'(FRAC_W);
	assign half    = lh_q >> 1;
	assign offset  = (half > DEN_W'(HALF_H)) ? half - DEN_W'(HALF_H) : '0;
	assign start_row = (half >= DEN_W'(HALF_H)) ? '0 : ROW_W'(DEN_W'(HALF_H) - half);
	assign end_sum = {1'b0, half} + (DEN_W + 1)'(HALF_H);
	assign end_row = (end_sum >= (DEN_W + 1)'(SCREEN_HEIGHT - 1)) ?
		ROW_W'(SCREEN_HEIGHT - 1) : ROW_W'(end_sum);

	always_comb begin
		case (cmd.div_sel)
			DIV_LH: begin
				div_num = NUM_W'(SCREEN_HEIGHT) << FRAC_W;
				div_den = DEN_W'(wall_distance_q16);
			end
			DIV_STEP: begin
				div_num = NUM_W'(1) << shamt;
				div_den = lh_q;
			end
			DIV_POS: begin
				div_num = NUM_W'(offset) << shamt;
				div_den = lh_q;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	rcwt_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_go),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	// pixel addressing
	assign pix_active = cur_row_q < end_row_q;
	assign hmask      = FRAC_W'((17'd1 << tex_h_log2_q) - 17'd1);
	assign trow       = tex_pos_q[POS_W-1:FRAC_W] & hmask;
	assign prod       = PROD_W'(trow) * PROD_W'(tex_width_q);
	assign idx_sum    = prod + PROD_W'(saved_tcol_q);
	assign pix_last   = ({1'b0, cur_row_q} + (ROW_W + 1)'(1)) == {1'b0, end_row_q};

	assign out_free = !res_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_h_log2_q <= HLOG_W'(6);
			tex_width_q  <= TEXW_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEX_H_LOG2: tex_h_log2_q <= cfg_data[HLOG_W-1:0];
				REG_TEX_WIDTH:  tex_width_q  <= cfg_data[TEXW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q    <= '0;
			end_row_q    <= '0;
			tex_pos_q    <= '0;
			tex_step_q   <= '0;
			saved_col_q  <= '0;
			saved_tcol_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.cap_item) begin
				saved_col_q  <= column;
				saved_tcol_q <= texture_column;
			end
			if (cmd.commit) begin
				cur_row_q  <= start_row;
				end_row_q  <= end_row;
				tex_step_q <= lh_zero ? '0 : step_new_q;
				tex_pos_q  <= lh_zero ? '0 : pos_new_q;
			end else if (cmd.pixel && pix_active) begin
				cur_row_q <= cur_row_q + ROW_W'(1);
				tex_pos_q <= tex_pos_q + tex_step_q;
			end
			if (cmd.commit || cmd.pixel) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			dist_zero_q <= (wall_distance_q16 == '0);
		end
		if (cmd.cap_lh) begin
			lh_q <= dist_zero_q ? '0 : DEN_W'(div_quo);
		end
		if (cmd.cap_step) begin
			step_new_q <= div_quo;
		end
		if (cmd.cap_pos) begin
			pos_new_q <= div_quo;
		end
		if (cmd.commit) begin
			span_start_q <= ROW_OUT_W'(start_row);
			span_end_q   <= ROW_OUT_W'(end_row);
			pix_valid_q  <= 1'b0;
			scr_col_q    <= '0;
			scr_row_q    <= '0;
			texel_q      <= '0;
			last_q       <= 1'b0;
		end else if (cmd.pixel) begin
			span_start_q <= '0;
			span_end_q   <= '0;
			pix_valid_q  <= pix_active;
			scr_col_q    <= pix_active ? saved_col_q : '0;
			scr_row_q    <= pix_active ? ROW_OUT_W'(cur_row_q) : '0;
			texel_q      <= pix_active ? idx_sum[TEXEL_W-1:0] : '0;
			last_q       <= pix_active && pix_last;
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.lh_zero  = lh_zero;
	assign sts.out_free = out_free;

	assign result_valid  = res_valid_q;
	assign span_start    = span_start_q;
	assign span_end      = span_end_q;
	assign pixel_valid   = pix_valid_q;
	assign screen_column = scr_col_q;
	assign screen_row    = scr_row_q;
	assign texel_index   = texel_q;
	assign last_pixel    = last_q;

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_row_q <= end_row_q)
		else $error("current row ran past span end");

	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pixel && pix_active) |=> cur_row_q == $past(cur_row_q) + ROW_W'(1))
		else $error("row did not advance after drawn pixel");

endmodule

/* hw/rtl/raycast_wall_column_texturer.sv */
// Pixel word: result registered on acceptance; one per cycle while output is free.
// Start word: up to three passes through the shared one-bit-per-cycle divider.
// Reset (asynchronous, active low): span state and result valid cleared, texture height
//   log2 back to 6 and width back to 64.
// ----------------------------------------------------------------------------
// raycast_wall_column_texturer
// Maps a raycast wall column onto a power-of-two-high texture and streams
// the texel address of each drawn row.
// ----------------------------------------------------------------------------
module raycast_wall_column_texturer #(
	parameter int SCREEN_HEIGHT = rcwt_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rcwt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rcwt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [rcwt_pkg::OPC_W-1:0]          opcode,
	input  logic [rcwt_pkg::DIST_W-1:0]         wall_distance_q16,
	input  logic [rcwt_pkg::COL_W-1:0]          column,
	input  logic [rcwt_pkg::TCOL_W-1:0]         texture_column,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [rcwt_pkg::ROW_OUT_W-1:0]      span_start,
	output logic [rcwt_pkg::ROW_OUT_W-1:0]      span_end,
	output logic                                pixel_valid,
	output logic [rcwt_pkg::COL_W-1:0]          screen_column,
	output logic [rcwt_pkg::ROW_OUT_W-1:0]      screen_row,
	output logic [rcwt_pkg::TEXEL_W-1:0]        texel_index,
	output logic                                last_pixel
);
	import rcwt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rcwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.opcode    (opcode),
		.item_ready(item_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcwt_dp #(
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.wall_distance_q16(wall_distance_q16),
		.column           (column),
		.texture_column   (texture_column),
		.cmd              (cmd),
		.sts              (sts),
		.result_ready     (result_ready),
		.result_valid     (result_valid),
		.span_start       (span_start),
		.span_end         (span_end),
		.pixel_valid      (pixel_valid),
		.screen_column    (screen_column),
		.screen_row       (screen_row),
		.texel_index      (texel_index),
		.last_pixel       (last_pixel)
	);

endmodule
